@@ src/fesg_pkg.sv @@
package fesg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 10;
  localparam int SCREEN_BITS  = COORD_BITS - 1;
  localparam int ROW_BITS     = COORD_BITS + 1;
  localparam int SQ_BITS      = 2 * RADIUS_BITS;
  localparam int NUM_BITS     = 4 * RADIUS_BITS;
  localparam int REM_BITS     = SQ_BITS + 1;
  localparam int CNT_BITS     = $clog2(NUM_BITS);
  localparam int SW_BITS      = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS + 1) + 1;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [SCREEN_BITS-1:0] MAX_X_RESET = SCREEN_BITS'(319);
  localparam logic [SCREEN_BITS-1:0] MAX_Y_RESET = SCREEN_BITS'(199);

  // vertical semi-axis is 4*r/5, i.e. 0.80 of the radius, as (4*r*ceil(2^14/5)) >> 14
  localparam logic [SQ_BITS-1:0]  B_RECIP    = SQ_BITS'(3277);
  localparam int                  B_SHIFT    = 14;
  localparam logic [CNT_BITS-1:0] DIV_STEPS  = CNT_BITS'(NUM_BITS - 1);
  localparam logic [CNT_BITS-1:0] SQRT_STEPS = CNT_BITS'(RADIUS_BITS - 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } unit_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_GO,
    ST_MUL_A2,
    ST_MUL_B2,
    ST_MUL_Y2,
    ST_MUL_NUM,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_EMIT
  } fesg_state_e;

  typedef struct packed {
    logic                go;
    unit_mode_e          mode;
    logic [NUM_BITS-1:0] operand;
    logic [SQ_BITS-1:0]  divisor;
  } unit_req_t;

  typedef struct packed {
    logic                   busy;
    logic [NUM_BITS-1:0]    quotient;
    logic [RADIUS_BITS-1:0] root;
  } unit_rsp_t;

endpackage

@@ src/fesg_cmd_if.sv @@
interface fesg_cmd_if import fesg_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [COORD_BITS-1:0]  x_center;
  logic signed [COORD_BITS-1:0]  y_center;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (
    output valid, cmd, x_center, y_center, radius,
    input  ready
  );

  modport sink (
    input  valid, cmd, x_center, y_center, radius,
    output ready
  );

endinterface

@@ src/fesg_span_if.sv @@
interface fesg_span_if import fesg_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic        [SCREEN_BITS-1:0] span_start;
  logic signed [COORD_BITS-1:0]  span_end;
  logic                          span_nonempty;
  logic signed [ROW_BITS-1:0]    row_below;
  logic                          row_below_valid;
  logic signed [ROW_BITS-1:0]    row_above;
  logic                          row_above_valid;
  logic                          last;

  modport source (
    output valid, span_start, span_end, span_nonempty, row_below, row_below_valid,
           row_above, row_above_valid, last,
    input  ready
  );

  modport sink (
    input  valid, span_start, span_end, span_nonempty, row_below, row_below_valid,
           row_above, row_above_valid, last,
    output ready
  );

endinterface

@@ src/fesg_iter_unit.sv @@
module fesg_iter_unit import fesg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  unit_mode_e             mode_q, mode_d;
  logic [NUM_BITS-1:0]    acc_q, acc_d;
  logic [REM_BITS-1:0]    rem_q, rem_d;
  logic [RADIUS_BITS-1:0] root_q, root_d;
  logic [SQ_BITS-1:0]     dsr_q, dsr_d;

  logic [REM_BITS-1:0]    lhs;
  logic [REM_BITS-1:0]    rhs;
  logic [REM_BITS:0]      diff;
  logic                   ge;

  // shared subtract and compare
  always_comb begin
    unique case (mode_q)
      MODE_DIV: begin
        lhs = {rem_q[REM_BITS-2:0], acc_q[NUM_BITS-1]};
        rhs = {1'b0, dsr_q};
      end
      MODE_SQRT: begin
        lhs = {rem_q[REM_BITS-3:0], acc_q[NUM_BITS-1 -: 2]};
        rhs = REM_BITS'({root_q, 2'b01});
      end
      default: begin
        lhs = '0;
        rhs = '0;
      end
    endcase
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = ~diff[REM_BITS];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    dsr_d  = dsr_q;
    if (req_i.go) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      rem_d  = '0;
      root_d = '0;
      dsr_d  = req_i.divisor;
      if (req_i.mode == MODE_SQRT) begin
        cnt_d = SQRT_STEPS;
        acc_d = {req_i.operand[SQ_BITS-1:0], {SQ_BITS{1'b0}}};
      end else begin
        cnt_d = DIV_STEPS;
        acc_d = req_i.operand;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_BITS-1:0] : lhs;
      unique case (mode_q)
        MODE_DIV: begin
          acc_d = {acc_q[NUM_BITS-2:0], ge};
        end
        MODE_SQRT: begin
          acc_d  = {acc_q[NUM_BITS-3:0], 2'b00};
          root_d = {root_q[RADIUS_BITS-2:0], ge};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= MODE_DIV;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = acc_q;
  assign rsp_o.root     = root_q;

endmodule

@@ src/filled_ellipse_span_generator_core.sv @@
// Filled ellipse span generator: a start transaction latches centre and radius and derives the
// vertical semi-axis (4*r/5) by a reciprocal multiply without producing a result; each step
// transaction produces one span for the next row pair (centre_row+y and centre_row-y), or an
// empty span flagged last once the ellipse is finished or none is active. The work is done by
// one shared restoring divide/square-root unit: 40 divide steps for (a^2*(b^2-y^2))/b^2 and
// 10 root steps, after four passes through a single 20x20 multiplier.
// The command side is not ready while a transaction is being worked on; a finished span waits
// in an output register so that the next command can be taken meanwhile, and a step that
// finds that register still full waits for it. max_x and max_y are written through the cfg
// port, and the user must write them only while idle; the block itself does not enforce it.
module filled_ellipse_span_generator_core import fesg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SCREEN_BITS-1:0]  cfg_data_i,
  fesg_cmd_if.sink                cmd_i,
  fesg_span_if.source             span_o
);

  fesg_state_e state_q, state_d;

  logic [SCREEN_BITS-1:0] max_x_q, max_x_d;
  logic [SCREEN_BITS-1:0] max_y_q, max_y_d;
  logic                   active_q, active_d;
  logic [RADIUS_BITS-1:0] y_q, y_d;
  logic                   produce_q, produce_d;
  logic                   out_valid_q, out_valid_d;

  logic signed [COORD_BITS-1:0] centre_col_q;
  logic signed [COORD_BITS-1:0] centre_row_q;
  logic [RADIUS_BITS-1:0]       a_q;
  logic [RADIUS_BITS-1:0]       b_q;
  logic [SQ_BITS-1:0]           a2_q;
  logic [SQ_BITS-1:0]           b2_q;
  logic [SQ_BITS-1:0]           y2_q;
  logic [NUM_BITS-1:0]          num_q;

  logic [SCREEN_BITS-1:0]       span_start_q;
  logic signed [COORD_BITS-1:0] span_end_q;
  logic                         span_nonempty_q;
  logic signed [ROW_BITS-1:0]   row_below_q;
  logic                         row_below_valid_q;
  logic signed [ROW_BITS-1:0]   row_above_q;
  logic                         row_above_valid_q;
  logic                         last_q;

  logic                   accept;
  logic                   out_free;
  logic                   row_pending;
  logic [RADIUS_BITS-1:0] y_next;
  logic                   ends_now;
  logic [RADIUS_BITS-1:0] b_new;

  logic [SQ_BITS-1:0]  mul_a;
  logic [SQ_BITS-1:0]  mul_b;
  logic [NUM_BITS-1:0] product;

  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  logic signed [SW_BITS-1:0] x_s, y_s, cc_s, cr_s, mx_s, my_s;
  logic signed [SW_BITS-1:0] xs_s, xe_s, xs_c, xe_c, yb_s, ya_s;

  logic [SCREEN_BITS-1:0]       span_start_n;
  logic signed [COORD_BITS-1:0] span_end_n;
  logic                         span_nonempty_n;
  logic signed [ROW_BITS-1:0]   row_below_n;
  logic                         row_below_valid_n;
  logic signed [ROW_BITS-1:0]   row_above_n;
  logic                         row_above_valid_n;
  logic                         last_n;

  fesg_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || span_o.ready;
  assign row_pending = active_q && (y_q < b_q);
  assign y_next      = y_q + 1'b1;
  assign ends_now    = (y_next >= b_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_e'(cmd_i.cmd) == CMD_START) begin
            state_d = ST_B_GO;
          end else if (row_pending) begin
            state_d = ST_MUL_A2;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_B_GO:    state_d = ST_IDLE;
      ST_MUL_A2:  state_d = ST_MUL_B2;
      ST_MUL_B2:  state_d = ST_MUL_Y2;
      ST_MUL_Y2:  state_d = ST_MUL_NUM;
      ST_MUL_NUM: state_d = ST_Q_GO;
      ST_Q_GO:    state_d = ST_Q_WAIT;
      ST_Q_WAIT:  if (!unit_rsp.busy) state_d = ST_R_GO;
      ST_R_GO:    state_d = ST_R_WAIT;
      ST_R_WAIT:  if (!unit_rsp.busy) state_d = ST_EMIT;
      ST_EMIT:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_i.ready      = 1'b0;
    unit_req.go      = 1'b0;
    unit_req.mode    = MODE_DIV;
    unit_req.operand = '0;
    unit_req.divisor = '0;
    mul_a            = '0;
    mul_b            = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
      end
      ST_B_GO: begin
        mul_a = SQ_BITS'({a_q, 2'b00});
        mul_b = B_RECIP;
      end
      ST_MUL_A2: begin
        mul_a = SQ_BITS'(a_q);
        mul_b = SQ_BITS'(a_q);
      end
      ST_MUL_B2: begin
        mul_a = SQ_BITS'(b_q);
        mul_b = SQ_BITS'(b_q);
      end
      ST_MUL_Y2: begin
        mul_a = SQ_BITS'(y_q);
        mul_b = SQ_BITS'(y_q);
      end
      ST_MUL_NUM: begin
        mul_a = a2_q;
        mul_b = b2_q - y2_q;
      end
      ST_Q_GO: begin
        unit_req.go      = 1'b1;
        unit_req.operand = num_q;
        unit_req.divisor = b2_q;
      end
      ST_R_GO: begin
        unit_req.go      = 1'b1;
        unit_req.mode    = MODE_SQRT;
        unit_req.operand = unit_rsp.quotient;
      end
      default: begin
        cmd_i.ready = 1'b0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign b_new   = product[B_SHIFT +: RADIUS_BITS];

  // span and row arithmetic for the emit step
  always_comb begin
    x_s  = SW_BITS'(unit_rsp.root);
    y_s  = SW_BITS'(y_q);
    cc_s = SW_BITS'(centre_col_q);
    cr_s = SW_BITS'(centre_row_q);
    mx_s = SW_BITS'(max_x_q);
    my_s = SW_BITS'(max_y_q);
    xs_s = cc_s - x_s;
    xe_s = cc_s + x_s;
    xs_c = (xs_s < 0) ? '0 : xs_s;
    xe_c = (xe_s > mx_s) ? mx_s : xe_s;
    yb_s = cr_s + y_s;
    ya_s = cr_s - y_s;
    if (produce_q) begin
      span_start_n      = xs_c[SCREEN_BITS-1:0];
      span_end_n        = xe_c[COORD_BITS-1:0];
      span_nonempty_n   = (xs_c < xe_c);
      row_below_n       = yb_s[ROW_BITS-1:0];
      row_below_valid_n = (yb_s >= 0) && (yb_s <= my_s);
      row_above_n       = ya_s[ROW_BITS-1:0];
      row_above_valid_n = (ya_s >= 0) && (ya_s <= my_s);
      last_n            = ends_now;
    end else begin
      span_start_n      = '0;
      span_end_n        = '0;
      span_nonempty_n   = 1'b0;
      row_below_n       = '0;
      row_below_valid_n = 1'b0;
      row_above_n       = '0;
      row_above_valid_n = 1'b0;
      last_n            = 1'b1;
    end
  end

  // control state updates
  always_comb begin
    max_x_d     = max_x_q;
    max_y_d     = max_y_q;
    active_d    = active_q;
    y_d         = y_q;
    produce_d   = produce_q;
    out_valid_d = out_valid_q && !span_o.ready;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_X: max_x_d = cfg_data_i;
        REG_MAX_Y: max_y_d = cfg_data_i;
        default:   max_x_d = max_x_q;
      endcase
    end
    if (accept) begin
      if (cmd_e'(cmd_i.cmd) == CMD_START) begin
        y_d      = '0;
        active_d = 1'b0;
      end else begin
        produce_d = row_pending;
      end
    end
    if (state_q == ST_B_GO) begin
      active_d = (b_new != '0);
    end
    if (state_q == ST_EMIT && out_free) begin
      out_valid_d = 1'b1;
      if (produce_q) begin
        y_d = y_next;
        if (ends_now) begin
          active_d = 1'b0;
        end
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_x_q     <= MAX_X_RESET;
      max_y_q     <= MAX_Y_RESET;
      active_q    <= 1'b0;
      y_q         <= '0;
      produce_q   <= 1'b0;
      out_valid_q <= 1'b0;
      b_q         <= '0;
    end else begin
      state_q     <= state_d;
      max_x_q     <= max_x_d;
      max_y_q     <= max_y_d;
      active_q    <= active_d;
      y_q         <= y_d;
      produce_q   <= produce_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_B_GO) begin
        b_q <= b_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && cmd_e'(cmd_i.cmd) == CMD_START) begin
      centre_col_q <= cmd_i.x_center;
      centre_row_q <= cmd_i.y_center;
      a_q          <= cmd_i.radius;
    end
    if (state_q == ST_MUL_A2) begin
      a2_q <= product[SQ_BITS-1:0];
    end
    if (state_q == ST_MUL_B2) begin
      b2_q <= product[SQ_BITS-1:0];
    end
    if (state_q == ST_MUL_Y2) begin
      y2_q <= product[SQ_BITS-1:0];
    end
    if (state_q == ST_MUL_NUM) begin
      num_q <= product;
    end
    if (state_q == ST_EMIT && out_free) begin
      span_start_q      <= span_start_n;
      span_end_q        <= span_end_n;
      span_nonempty_q   <= span_nonempty_n;
      row_below_q       <= row_below_n;
      row_below_valid_q <= row_below_valid_n;
      row_above_q       <= row_above_n;
      row_above_valid_q <= row_above_valid_n;
      last_q            <= last_n;
    end
  end

  assign span_o.valid           = out_valid_q;
  assign span_o.span_start      = span_start_q;
  assign span_o.span_end        = span_end_q;
  assign span_o.span_nonempty   = span_nonempty_q;
  assign span_o.row_below       = row_below_q;
  assign span_o.row_below_valid = row_below_valid_q;
  assign span_o.row_above       = row_above_q;
  assign span_o.row_above_valid = row_above_valid_q;
  assign span_o.last            = last_q;

endmodule

@@ verif/tb_filled_ellipse_span_generator_core.sv @@
`timescale 1ns / 100ps

module tb_filled_ellipse_span_generator_core;
  import fesg_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    cmd_e                          cmd;
    logic signed [COORD_BITS-1:0]  x_center;
    logic signed [COORD_BITS-1:0]  y_center;
    logic        [RADIUS_BITS-1:0] radius;
  } ellipse_cmd_t;

  typedef struct packed {
    logic        [SCREEN_BITS-1:0] span_start;
    logic signed [COORD_BITS-1:0]  span_end;
    logic                          span_nonempty;
    logic signed [ROW_BITS-1:0]    row_below;
    logic                          row_below_valid;
    logic signed [ROW_BITS-1:0]    row_above;
    logic                          row_above_valid;
    logic                          last;
  } span_t;

  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_AT      = 450;
  localparam int HOLD_CYCLES  = 700;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we_i   = 1'b0;
  cfg_reg_e               cfg_idx_i  = REG_MAX_X;
  logic [SCREEN_BITS-1:0] cfg_data_i = '0;

  fesg_cmd_if  cmd_if ();
  fesg_span_if span_if ();

  filled_ellipse_span_generator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .span_o     (span_if)
  );

  always #2 clk_i = ~clk_i;

  // predicted block state
  logic signed [COORD_BITS-1:0]  pred_col    = '0;
  logic signed [COORD_BITS-1:0]  pred_row    = '0;
  logic        [RADIUS_BITS-1:0] pred_a      = '0;
  logic        [RADIUS_BITS-1:0] pred_b      = '0;
  logic        [RADIUS_BITS-1:0] pred_y      = '0;
  logic                          pred_active = 1'b0;
  logic        [SCREEN_BITS-1:0] pred_max_x  = MAX_X_RESET;
  logic        [SCREEN_BITS-1:0] pred_max_y  = MAX_Y_RESET;

  ellipse_cmd_t cmd_backlog[$];
  span_t        spans_due[$];

  int unsigned failures   = 0;
  int unsigned cmds_taken = 0;
  bit          cmd_taken  = 1'b0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;

  function automatic int unsigned floor_root(u64_t val);
    int unsigned root;
    int unsigned trial;
    int          i;
    root = 0;
    for (i = RADIUS_BITS - 1; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (u64_t'(trial) * trial <= val) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // advances the predicted state; returns 1 when the command yields a span
  function automatic bit ellipse_step(input ellipse_cmd_t c, output span_t s);
    u64_t a2, b2, y2, q;
    int   half, xs, xe, yb, ya;
    s = '0;
    if (c.cmd == CMD_START) begin
      pred_col    = c.x_center;
      pred_row    = c.y_center;
      pred_a      = c.radius;
      pred_b      = RADIUS_BITS'((4 * int'(c.radius)) / 5);
      pred_y      = '0;
      pred_active = (pred_b != '0);
      return 1'b0;
    end
    if (!pred_active || pred_y >= pred_b) begin
      pred_active = 1'b0;
      s.last      = 1'b1;
      return 1'b1;
    end
    a2   = u64_t'(pred_a) * pred_a;
    b2   = u64_t'(pred_b) * pred_b;
    y2   = u64_t'(pred_y) * pred_y;
    q    = (a2 * (b2 - y2)) / b2;
    half = int'(floor_root(q));
    xs   = int'(pred_col) - half;
    xe   = int'(pred_col) + half;
    yb   = int'(pred_row) + int'(pred_y);
    ya   = int'(pred_row) - int'(pred_y);
    if (xs < 0) begin
      xs = 0;
    end
    if (xe > int'(pred_max_x)) begin
      xe = int'(pred_max_x);
    end
    s.span_start      = SCREEN_BITS'(xs);
    s.span_end        = COORD_BITS'(xe);
    s.span_nonempty   = (xs < xe);
    s.row_below       = ROW_BITS'(yb);
    s.row_below_valid = (yb >= 0) && (yb <= int'(pred_max_y));
    s.row_above       = ROW_BITS'(ya);
    s.row_above_valid = (ya >= 0) && (ya <= int'(pred_max_y));
    pred_y = pred_y + 1'b1;
    if (pred_y >= pred_b) begin
      pred_active = 1'b0;
      s.last      = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin : span_monitor
    ellipse_cmd_t taken;
    span_t        got, want;
    cmd_taken <= cmd_if.valid && cmd_if.ready;
    if (span_if.valid && span_if.ready) begin
      got.span_start      = span_if.span_start;
      got.span_end        = span_if.span_end;
      got.span_nonempty   = span_if.span_nonempty;
      got.row_below       = span_if.row_below;
      got.row_below_valid = span_if.row_below_valid;
      got.row_above       = span_if.row_above;
      got.row_above_valid = span_if.row_above_valid;
      got.last            = span_if.last;
      if (spans_due.size() == 0) begin
        $display("%0t: unexpected span transaction, expected none, actual %h", $time, got);
        failures++;
      end else begin
        want = spans_due.pop_front();
        check_field("span_start", 16'(want.span_start), 16'(got.span_start));
        check_field("span_end", 16'(want.span_end), 16'(got.span_end));
        check_field("span_nonempty", 16'(want.span_nonempty), 16'(got.span_nonempty));
        check_field("row_below", 16'(want.row_below), 16'(got.row_below));
        check_field("row_below_valid", 16'(want.row_below_valid),
                    16'(got.row_below_valid));
        check_field("row_above", 16'(want.row_above), 16'(got.row_above));
        check_field("row_above_valid", 16'(want.row_above_valid),
                    16'(got.row_above_valid));
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
    if (cmd_if.valid && cmd_if.ready) begin
      taken.cmd      = cmd_e'(cmd_if.cmd);
      taken.x_center = cmd_if.x_center;
      taken.y_center = cmd_if.y_center;
      taken.radius   = cmd_if.radius;
      cmds_taken++;
      if (ellipse_step(taken, want)) begin
        spans_due.push_back(want);
      end
    end
  end

  // command driver: bursts with random gaps while tx_idle_en is set, back to back otherwise
  int unsigned burst_left = 4;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : cmd_driver
    ellipse_cmd_t nxt;
    if (cmd_taken || !cmd_if.valid) begin
      if (gap_left != 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_if.valid    <= 1'b1;
        cmd_if.cmd      <= nxt.cmd;
        cmd_if.x_center <= nxt.x_center;
        cmd_if.y_center <= nxt.y_center;
        cmd_if.radius   <= nxt.radius;
        if (tx_idle_en) begin
          if (burst_left != 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 20);
          end
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // span receiver: stall pattern of its own while rx_idle_en is set, plus one long hold-off
  int unsigned rx_phase     = 0;
  int unsigned rx_period    = 8;
  int unsigned rx_low       = 0;
  int unsigned rx_hold      = 0;
  bit          rx_hold_done = 1'b0;

  always @(negedge clk_i) begin : span_receiver
    if (!rx_hold_done && cmds_taken >= HOLD_AT) begin
      rx_hold      = HOLD_CYCLES;
      rx_hold_done = 1'b1;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      span_if.ready <= 1'b0;
    end else if (!rx_idle_en) begin
      span_if.ready <= 1'b1;
    end else begin
      span_if.ready <= (rx_phase >= rx_low);
      rx_phase++;
      if (rx_phase >= rx_period) begin
        rx_phase  = 0;
        rx_period = $urandom_range(2, 100);
        rx_low    = $urandom_range(0, rx_period / 2);
      end
    end
  end

  task automatic program_limits(logic [SCREEN_BITS-1:0] mx, logic [SCREEN_BITS-1:0] my);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_X;
    cfg_data_i <= mx;
    @(negedge clk_i);
    cfg_idx_i  <= REG_MAX_Y;
    cfg_data_i <= my;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pred_max_x = mx;
    pred_max_y = my;
  endtask

  task automatic queue_start(int xc, int yc, int rad);
    ellipse_cmd_t c;
    c.cmd      = CMD_START;
    c.x_center = COORD_BITS'(xc);
    c.y_center = COORD_BITS'(yc);
    c.radius   = RADIUS_BITS'(rad);
    cmd_backlog.push_back(c);
  endtask

  // step fields carry random content, the block ignores them
  task automatic queue_steps(int unsigned n);
    ellipse_cmd_t c;
    repeat (n) begin
      c.cmd      = CMD_STEP;
      c.x_center = COORD_BITS'($urandom);
      c.y_center = COORD_BITS'($urandom);
      c.radius   = RADIUS_BITS'($urandom);
      cmd_backlog.push_back(c);
    end
  endtask

  function automatic int near_screen();
    if ($urandom_range(0, 1) != 0) begin
      return int'($urandom_range(0, 700)) - 30;
    end
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned added, rad, semi_v, steps;
    ellipse_cmd_t c;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       rad = $urandom_range(201, 1023);
          1, 2:    rad = $urandom_range(31, 200);
          default: rad = $urandom_range(0, 30);
        endcase
        semi_v = (4 * rad) / 5;
        steps  = (semi_v <= 40) ? semi_v + $urandom_range(0, 2) : $urandom_range(1, 40);
        queue_start(near_screen(), near_screen(), rad);
        queue_steps(steps);
        added += 1 + steps;
      end else begin
        c.cmd      = cmd_e'($urandom_range(0, 1));
        c.x_center = COORD_BITS'($urandom);
        c.y_center = COORD_BITS'($urandom);
        c.radius   = RADIUS_BITS'($urandom);
        cmd_backlog.push_back(c);
        added++;
      end
    end
  endtask

  // waits until every command is taken and every span has come back
  task automatic drain_block();
    while (cmd_backlog.size() != 0 || cmd_if.valid || spans_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [SCREEN_BITS-1:0] mx, logic [SCREEN_BITS-1:0] my,
                           bit tx_idle, bit rx_idle, int unsigned count);
    program_limits(mx, my);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    queue_random(count);
    drain_block();
  endtask

  initial begin : stimulus
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = CMD_START;
    cmd_if.x_center = '0;
    cmd_if.y_center = '0;
    cmd_if.radius   = '0;
    span_if.ready   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_limits(MAX_X_RESET, MAX_Y_RESET);
    // step with nothing active, radius too small for any row
    queue_steps(1);
    queue_start(10, 10, 0);
    queue_steps(1);
    queue_start(10, 10, 1);
    queue_steps(1);
    // one-row ellipse, then a step past its end
    queue_start(100, 50, 2);
    queue_steps(2);
    // far corner: left clip, empty spans, rows off screen
    queue_start(-2048, -2048, 5);
    queue_steps(5);
    // widest radius at the other corner, abandoned by a new start
    queue_start(2047, 2047, 1023);
    queue_steps(3);
    queue_start(160, 100, 10);
    queue_steps(2);
    queue_start(0, 0, 1023);
    queue_steps(2);
    drain_block();

    run_phase(11'd639, 11'd399, 1'b1, 1'b1, 250);
    run_phase(11'd0, 11'd0, 1'b0, 1'b0, 250);
    run_phase(11'd2047, 11'd2047, 1'b1, 1'b1, 250);
    run_phase(SCREEN_BITS'($urandom), SCREEN_BITS'($urandom), 1'b1, 1'b0, 250);

    if (spans_due.size() != 0) begin
      $display("%0t: %0d expected span transactions never arrived", $time, spans_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("filled_ellipse_span_generator_core verification clean");
    end else begin
      $display("filled_ellipse_span_generator_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("filled_ellipse_span_generator_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
src/fesg_pkg.sv
src/fesg_cmd_if.sv
src/fesg_span_if.sv
src/fesg_iter_unit.sv
src/filled_ellipse_span_generator_core.sv
verif/tb_filled_ellipse_span_generator_core.sv
